### src/sem4_pkg.sv
package sem4_pkg;

   localparam int MAX_LINE_WORDS = 2048;
   localparam int ADDR_W         = $clog2(MAX_LINE_WORDS);
   localparam int WORD_W         = 32;
   localparam int PIX_W          = 8;
   localparam int LANES          = WORD_W / PIX_W;
   localparam int TAPS           = 9;
   localparam int CFG_W          = 12;
   localparam int DIM_W          = CFG_W + 1;
   localparam int CSR_INDEX_W    = 1;
   localparam int MIN_DIM        = 3;

   localparam logic [CFG_W-1:0] LINE_WORDS_RESET  = CFG_W'(1440);
   localparam logic [CFG_W-1:0] FRAME_LINES_RESET = CFG_W'(1080);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LINE_WORDS  = 1'b0,
      CSR_FRAME_LINES = 1'b1
   } csr_index_type;

   // one 3x3 neighborhood of one lane, row-major from top left
   typedef logic [TAPS-1:0][PIX_W-1:0] taps_type;

   // both line stores share one address, so they live in one wide entry
   typedef struct packed {
      logic [WORD_W-1:0] upper;
      logic [WORD_W-1:0] middle;
   } line_pair_type;

   typedef struct packed {
      logic emit;
      logic eol;
      logic eof;
   } tag_type;

endpackage

### src/sem4_line_store.sv
module sem4_line_store
   import sem4_pkg::*;
(
   input  logic                clock,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   rd_addr,
   output line_pair_type       rd_data,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  line_pair_type       wr_data
);

   line_pair_type mem_ff [MAX_LINE_WORDS];
   line_pair_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read data holds while the pipeline is stalled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/sem4_lane.sv
module sem4_lane
   import sem4_pkg::*;
(
   input  logic              clock,
   input  logic              en,
   input  taps_type          taps,
   output logic [PIX_W-1:0]  mag
);

   localparam int SUM_W  = PIX_W + 2;
   localparam int GRAD_W = SUM_W + 1;

   logic [SUM_W-1:0]         top_sum, bot_sum, left_sum, right_sum;
   logic signed [GRAD_W-1:0] gx_in, gy_in, gx_ff, gy_ff;
   logic [SUM_W-1:0]         abs_x, abs_y;
   logic [GRAD_W-1:0]        total;
   logic [PIX_W-1:0]         mag_in, mag_ff;

   always_comb begin
      top_sum   = SUM_W'(taps[0]) + SUM_W'({taps[1], 1'b0}) + SUM_W'(taps[2]);
      bot_sum   = SUM_W'(taps[6]) + SUM_W'({taps[7], 1'b0}) + SUM_W'(taps[8]);
      left_sum  = SUM_W'(taps[0]) + SUM_W'({taps[3], 1'b0}) + SUM_W'(taps[6]);
      right_sum = SUM_W'(taps[2]) + SUM_W'({taps[5], 1'b0}) + SUM_W'(taps[8]);
      gx_in     = $signed({1'b0, top_sum}) - $signed({1'b0, bot_sum});
      gy_in     = $signed({1'b0, left_sum}) - $signed({1'b0, right_sum});
   end

   always_comb begin
      abs_x  = gx_ff[GRAD_W-1] ? SUM_W'(-gx_ff) : SUM_W'(gx_ff);
      abs_y  = gy_ff[GRAD_W-1] ? SUM_W'(-gy_ff) : SUM_W'(gy_ff);
      total  = GRAD_W'(abs_x) + GRAD_W'(abs_y);
      mag_in = total[GRAD_W-1:3];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         gx_ff  <= gx_in;
         gy_ff  <= gy_in;
         mag_ff <= mag_in;
      end
   end

   assign mag = mag_ff;

endmodule

### src/sobel_edge_magnitude_4lane_top.sv
// channel  | direction | ports                          | contents
// req      | in        | req_tvalid/tready/tdata        | pixel words, raster order
// rsp      | out       | rsp_tvalid/tready/tdata/tlast/ | edge words of interior positions
//          |           | tuser                          |
// csr      | in        | csr_valid/ready/index/data     | line_words, frame_lines
//
// one pixel beat per clock sustained while rsp is not stalled; a result passes the
// registered line store read and the two lane stages before it leaves
// synchronous reset clears counters and valids and loads the configuration defaults;
// data registers and line stores are not cleared
// a stalled rsp beat holds the whole pipeline and deasserts req_tready
// csr writes are always taken and act at once
module sobel_edge_magnitude_4lane_top
   import sem4_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [WORD_W-1:0]       req_tdata,   // pixel_word
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [WORD_W-1:0]       rsp_tdata,   // edge_word
   output logic                    rsp_tlast,   // end_of_line
   output logic                    rsp_tuser,   // end_of_frame
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CFG_W-1:0]        csr_data
);

   logic                en, accept;
   logic [CFG_W-1:0]    line_words_ff, frame_lines_ff;
   logic [DIM_W-1:0]    width_eff, height_eff;
   logic [ADDR_W-1:0]   col_ff, col_cur, col_in;
   logic [CFG_W-1:0]    row_ff, row_cur, row_in;
   logic                last_col, last_row;
   tag_type             tag_in;

   logic                s1_valid_ff;
   tag_type             s1_tag_ff;
   logic [WORD_W-1:0]   s1_bot_ff;
   logic [ADDR_W-1:0]   s1_addr_ff;
   tag_type             s2_tag_ff;

   line_pair_type       rd_pair, wr_pair;
   logic                wr_en;
   logic [WORD_W-1:0]   win_ff [6];

   logic                rsp_tvalid_ff, rsp_tlast_ff, rsp_tuser_ff;
   logic [WORD_W-1:0]   edge_word;

   assign en         = !rsp_tvalid_ff || rsp_tready;
   assign accept     = req_tvalid && en;
   assign req_tready = en;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_words_ff  <= LINE_WORDS_RESET;
         frame_lines_ff <= FRAME_LINES_RESET;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_LINE_WORDS:  line_words_ff  <= csr_data;
            CSR_FRAME_LINES: frame_lines_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // out-of-range settings act as the nearest legal size
   always_comb begin
      if (DIM_W'(line_words_ff) < DIM_W'(MIN_DIM)) begin
         width_eff = DIM_W'(MIN_DIM);
      end else if (DIM_W'(line_words_ff) > DIM_W'(MAX_LINE_WORDS)) begin
         width_eff = DIM_W'(MAX_LINE_WORDS);
      end else begin
         width_eff = DIM_W'(line_words_ff);
      end
      if (DIM_W'(frame_lines_ff) < DIM_W'(MIN_DIM)) begin
         height_eff = DIM_W'(MIN_DIM);
      end else begin
         height_eff = DIM_W'(frame_lines_ff);
      end
   end

   // counters past a shrunken bound restart at zero
   always_comb begin
      col_cur  = (DIM_W'(col_ff) >= width_eff) ? '0 : col_ff;
      row_cur  = (DIM_W'(row_ff) >= height_eff) ? '0 : row_ff;
      last_col = DIM_W'(col_cur) == (width_eff - 1'b1);
      last_row = DIM_W'(row_cur) == (height_eff - 1'b1);
      col_in   = last_col ? '0 : col_cur + 1'b1;
      if (last_col) begin
         row_in = last_row ? '0 : row_cur + 1'b1;
      end else begin
         row_in = row_cur;
      end
      tag_in.emit = (row_cur >= CFG_W'(2)) && (col_cur >= ADDR_W'(2));
      tag_in.eol  = last_col;
      tag_in.eof  = last_col && last_row;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         row_ff        <= '0;
         s1_valid_ff   <= 1'b0;
         s1_tag_ff     <= '0;
         s2_tag_ff     <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (en) begin
            s1_valid_ff      <= req_tvalid;
            s1_tag_ff        <= tag_in;
            s2_tag_ff        <= {s1_valid_ff && s1_tag_ff.emit, s1_tag_ff.eol, s1_tag_ff.eof};
            rsp_tvalid_ff    <= s2_tag_ff.emit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_bot_ff    <= req_tdata;
         s1_addr_ff   <= col_cur;
         rsp_tlast_ff <= s2_tag_ff.eol;
         rsp_tuser_ff <= s2_tag_ff.eof;
      end
   end

   // line above moves up one store, the new word becomes the line above
   assign wr_en          = en && s1_valid_ff;
   assign wr_pair.upper  = rd_pair.middle;
   assign wr_pair.middle = s1_bot_ff;

   sem4_line_store u_line_store (
      .clock   (clock),
      .rd_en   (en),
      .rd_addr (col_cur),
      .rd_data (rd_pair),
      .wr_en   (wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (wr_pair)
   );

   // window columns c-2 and c-1 for top, middle and bottom rows
   always_ff @(posedge clock) begin
      if (wr_en) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= rd_pair.upper;
         win_ff[2] <= win_ff[3];
         win_ff[3] <= rd_pair.middle;
         win_ff[4] <= win_ff[5];
         win_ff[5] <= s1_bot_ff;
      end
   end

   for (genvar k = 0; k < LANES; k++) begin : g_lane
      taps_type taps;

      always_comb begin
         taps[0] = win_ff[0][k*PIX_W +: PIX_W];
         taps[1] = win_ff[1][k*PIX_W +: PIX_W];
         taps[2] = rd_pair.upper[k*PIX_W +: PIX_W];
         taps[3] = win_ff[2][k*PIX_W +: PIX_W];
         taps[4] = win_ff[3][k*PIX_W +: PIX_W];
         taps[5] = rd_pair.middle[k*PIX_W +: PIX_W];
         taps[6] = win_ff[4][k*PIX_W +: PIX_W];
         taps[7] = win_ff[5][k*PIX_W +: PIX_W];
         taps[8] = s1_bot_ff[k*PIX_W +: PIX_W];
      end

      sem4_lane u_lane (
         .clock (clock),
         .en    (en),
         .taps  (taps),
         .mag   (edge_word[k*PIX_W +: PIX_W])
      );
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = edge_word;
   assign rsp_tlast  = rsp_tlast_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

### src/sem4_checker.sv
module sem4_checker
   import sem4_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tready,
   input  logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  logic [WORD_W-1:0]       rsp_tdata,
   input  logic                    rsp_tlast,
   input  logic                    rsp_tuser
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp beat present after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled rsp beat changed");

   a_eof_on_eol: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("end of frame without end of line");

   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid || rsp_tready |-> req_tready)
      else $error("input stalled while output free");

endmodule

bind sobel_edge_magnitude_4lane_top sem4_checker u_sem4_checker (.*);

### tb/sobel_edge_magnitude_4lane_top_test.sv
module sobel_edge_magnitude_4lane_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import sem4_pkg::*;

   localparam int RANDOM_ITEMS = 1230;
   localparam int NO_IDLE_AFTER = 1050;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES = 200;
   localparam int STUCK_LIMIT = 4000;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic              eol;
      logic              eof;
   } edge_beat_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [WORD_W-1:0]      req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [WORD_W-1:0]      rsp_tdata;
   logic                   rsp_tlast;
   logic                   rsp_tuser;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]       csr_data = '0;

   sobel_edge_magnitude_4lane_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state
   logic [CFG_W-1:0]  cfg_line_words = LINE_WORDS_RESET;
   logic [CFG_W-1:0]  cfg_frame_lines = FRAME_LINES_RESET;
   logic [WORD_W-1:0] upper_line [MAX_LINE_WORDS];
   logic [WORD_W-1:0] middle_line [MAX_LINE_WORDS];
   bit                up_def [MAX_LINE_WORDS];
   bit                mid_def [MAX_LINE_WORDS];
   logic [WORD_W-1:0] win [6];
   int unsigned       cur_row = 0;
   int unsigned       cur_col = 0;

   logic [WORD_W-1:0] pix_pending [$];
   edge_beat_type     edge_expected [$];
   edge_beat_type     edge_want;

   int  pix_queued = 0;
   int  pix_accepted = 0;
   int  edges_seen = 0;
   int  mismatches = 0;
   int  csr_writes = 0;
   int  frames_ended = 0;
   int  send_idle_rate = 0;
   int  recv_idle_rate = 0;
   bit  no_idle = 1'b0;
   int  gap_left = 0;
   int  stall_left = 0;
   int  hold_left = 0;
   int  holds_requested = 0;
   int  holds_started = 0;
   int  stuck_cycles = 0;

   function automatic int unsigned eff_width(input logic [CFG_W-1:0] v);
      if (v < MIN_DIM) return MIN_DIM;
      if (v > MAX_LINE_WORDS) return MAX_LINE_WORDS;
      return 32'(v);
   endfunction

   function automatic int unsigned eff_height(input logic [CFG_W-1:0] v);
      if (v < MIN_DIM) return MIN_DIM;
      return 32'(v);
   endfunction

   function automatic void predict_edge(input logic [WORD_W-1:0] pix);
      int unsigned       w, h, col, row;
      logic [WORD_W-1:0] top, mid;
      logic [WORD_W-1:0] nb [TAPS];
      int                px [TAPS];
      int                gx, gy;
      edge_beat_type     beat;
      w = eff_width(cfg_line_words);
      h = eff_height(cfg_frame_lines);
      col = cur_col;
      row = cur_row;
      if (col >= w) col = 0;
      if (row >= h) row = 0;
      top = upper_line[col];
      mid = middle_line[col];
      upper_line[col] = mid;
      middle_line[col] = pix;
      up_def[col] = mid_def[col];
      mid_def[col] = 1'b1;
      if (row >= 2 && col >= 2) begin
         nb[0] = win[0]; nb[1] = win[1]; nb[2] = top;
         nb[3] = win[2]; nb[4] = win[3]; nb[5] = mid;
         nb[6] = win[4]; nb[7] = win[5]; nb[8] = pix;
         beat = '0;
         for (int lane = 0; lane < LANES; lane++) begin
            for (int t = 0; t < TAPS; t++) px[t] = int'(nb[t][PIX_W*lane +: PIX_W]);
            gx = px[0] + 2 * px[1] + px[2] - px[6] - 2 * px[7] - px[8];
            gy = px[0] - px[2] + 2 * px[3] - 2 * px[5] + px[6] - px[8];
            if (gx < 0) gx = -gx;
            if (gy < 0) gy = -gy;
            beat.word[PIX_W*lane +: PIX_W] = PIX_W'((gx + gy) >> 3);
         end
         beat.eol = (col == w - 1);
         beat.eof = beat.eol && (row == h - 1);
         if (beat.eof) frames_ended++;
         edge_expected.push_back(beat);
      end
      win[0] = win[1]; win[1] = top;
      win[2] = win[3]; win[3] = mid;
      win[4] = win[5]; win[5] = pix;
      col++;
      if (col >= w) begin
         col = 0;
         row++;
         if (row >= h) row = 0;
      end
      cur_col = col;
      cur_row = row;
   endfunction

   // a new width must never make an interior result read a line store entry
   // that was never written
   function automatic bit width_is_safe(input int unsigned w_new, input int unsigned h_new);
      int unsigned r, c;
      bit          ok;
      ok = 1'b1;
      r = (cur_row >= h_new) ? 0 : cur_row;
      c = (cur_col >= w_new) ? 0 : cur_col;
      if (r != 0) begin
         for (int i = 0; i < w_new; i++) begin
            if (!mid_def[i]) ok = 1'b0;
            if ((r >= 2 || i < c) && !up_def[i]) ok = 1'b0;
         end
      end
      return ok;
   endfunction

   function automatic logic [WORD_W-1:0] random_pixel();
      logic [WORD_W-1:0] v;
      for (int lane = 0; lane < LANES; lane++) begin
         case ($urandom_range(3, 0))
            0:       v[PIX_W*lane +: PIX_W] = 8'h00;
            1:       v[PIX_W*lane +: PIX_W] = 8'hff;
            default: v[PIX_W*lane +: PIX_W] = PIX_W'($urandom_range(255, 0));
         endcase
      end
      return v;
   endfunction

   function automatic int pick_idle_rate();
      if ($urandom_range(3, 0) == 0) return 0;
      return $urandom_range(6, 1);
   endfunction

   task automatic queue_pixel(input logic [WORD_W-1:0] pix);
      predict_edge(pix);
      pix_pending.push_back(pix);
      pix_queued++;
   endtask

   // wait for every beat to go in and every edge word to come out
   task automatic settle();
      while (pix_accepted != pix_queued || edge_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic align_to_frame();
      while (cur_col != 0 || cur_row != 0) queue_pixel(random_pixel());
      settle();
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CFG_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_LINE_WORDS:  cfg_line_words = val;
         CSR_FRAME_LINES: cfg_frame_lines = val;
         default: ;
      endcase
      csr_writes++;
   endtask

   // pixel beat driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) pix_accepted++;
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pix_pending.size() > 0 && !no_idle && send_idle_rate > 0 &&
                         $urandom_range(31, 0) < send_idle_rate) begin
               gap_left = $urandom_range(12, 1) - 1;
               req_tvalid <= 1'b0;
            end else if (pix_pending.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tdata <= pix_pending.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // edge beat monitor and receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            edges_seen++;
            if (edge_expected.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected edge beat: data %h last %b user %b",
                           rsp_tdata, rsp_tlast, rsp_tuser);
            end else begin
               edge_want = edge_expected.pop_front();
               if (rsp_tdata !== edge_want.word || rsp_tlast !== edge_want.eol ||
                   rsp_tuser !== edge_want.eof) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("edge beat %0d: expected %h/%b/%b, got %h/%b/%b", edges_seen,
                              edge_want.word, edge_want.eol, edge_want.eof,
                              rsp_tdata, rsp_tlast, rsp_tuser);
               end
            end
         end
         if (holds_started < holds_requested) begin
            holds_started++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!no_idle && recv_idle_rate > 0 &&
                      $urandom_range(31, 0) < recv_idle_rate) begin
            stall_left = $urandom_range(12, 1) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("no beat for %0d cycles", stuck_cycles);
         $display("Verification failed");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      logic [WORD_W-1:0] dword;
      logic [CFG_W-1:0]  w_val, h_val;
      int unsigned       n, frame_words;
      int                phase, start, rand_items;
      for (int i = 0; i < 6; i++) win[i] = '0;
      for (int i = 0; i < MAX_LINE_WORDS; i++) begin
         upper_line[i] = '0;
         middle_line[i] = '0;
         up_def[i] = 1'b0;
         mid_def[i] = 1'b0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // a few words at the reset geometry, all in the top border
      queue_pixel(32'h0000_0000);
      queue_pixel(32'hffff_ffff);
      queue_pixel(32'h8080_8080);
      queue_pixel(32'h7f7f_7f7f);
      settle();
      // both below range, so the smallest 3x3 frame; the column wraps at once
      write_csr(CSR_LINE_WORDS, '0);
      write_csr(CSR_FRAME_LINES, CFG_W'(1));
      // lane 0 top edge, lane 1 left edge, lane 2 largest magnitude, lane 3 flat
      for (int f = 0; f < 2; f++) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               dword[7:0]   = (r == 0) ? 8'hff : 8'h00;
               dword[15:8]  = (c == 0) ? 8'hff : 8'h00;
               dword[23:16] = (r == 0 || c == 0) ? 8'hff : 8'h00;
               dword[31:24] = 8'hff;
               queue_pixel(f != 0 ? ~dword : dword);
            end
         end
      end

      rand_items = 0;
      phase = 0;
      while (rand_items < RANDOM_ITEMS) begin
         settle();
         no_idle = (rand_items >= NO_IDLE_AFTER);
         send_idle_rate = no_idle ? 0 : pick_idle_rate();
         recv_idle_rate = no_idle ? 0 : pick_idle_rate();
         start = pix_queued;
         case (phase)
            2: begin
               // receiver holds off while the sender keeps offering beats
               align_to_frame();
               send_idle_rate = 0;
               write_csr(CSR_LINE_WORDS, CFG_W'(10));
               write_csr(CSR_FRAME_LINES, CFG_W'(12));
               holds_requested++;
               repeat (120) queue_pixel(random_pixel());
            end
            8: begin
               // tallest frame, then cut short so the row count wraps
               align_to_frame();
               write_csr(CSR_LINE_WORDS, CFG_W'(3));
               write_csr(CSR_FRAME_LINES, '1);
               repeat (30) queue_pixel(random_pixel());
               settle();
               write_csr(CSR_FRAME_LINES, CFG_W'(5));
               repeat (30) queue_pixel(random_pixel());
            end
            11: begin
               // width shrinks under the current column, old entries stay in use
               align_to_frame();
               write_csr(CSR_LINE_WORDS, CFG_W'(12));
               write_csr(CSR_FRAME_LINES, CFG_W'(6));
               repeat (45) queue_pixel(random_pixel());
               settle();
               write_csr(CSR_LINE_WORDS, CFG_W'(4));
               repeat (48) queue_pixel(random_pixel());
            end
            default: begin
               case ($urandom_range(9, 0))
                  0:       w_val = CFG_W'($urandom_range(2, 0));
                  1:       w_val = CFG_W'($urandom_range(40, 15));
                  default: w_val = CFG_W'($urandom_range(14, 3));
               endcase
               h_val = ($urandom_range(9, 0) == 0) ? CFG_W'($urandom_range(2, 0))
                                                   : CFG_W'($urandom_range(8, 3));
               if (!width_is_safe(eff_width(w_val), eff_height(h_val)))
                  w_val = cfg_line_words;
               if ($urandom_range(1, 0) != 0) begin
                  write_csr(CSR_LINE_WORDS, w_val);
                  write_csr(CSR_FRAME_LINES, h_val);
               end else begin
                  write_csr(CSR_FRAME_LINES, h_val);
                  write_csr(CSR_LINE_WORDS, w_val);
               end
               frame_words = eff_width(w_val) * eff_height(h_val);
               if ($urandom_range(3, 0) != 0)
                  n = (frame_words > 100) ? frame_words : frame_words * $urandom_range(3, 1);
               else
                  n = $urandom_range(frame_words, 1);
               if (n > RANDOM_ITEMS - rand_items) n = 32'(RANDOM_ITEMS - rand_items);
               repeat (n) queue_pixel(random_pixel());
            end
         endcase
         rand_items += pix_queued - start;
         phase++;
      end
      settle();

      $display("covered %0d pixel beats, %0d edge beats, %0d frame ends, %0d csr writes",
               pix_queued, edges_seen, frames_ended, csr_writes);
      $display("geometries from the clamped minimum to 40 words per line, width shrink,");
      $display("row wrap, a long receiver hold and random stalls on both sides");
      if (mismatches == 0 && edge_expected.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("Verification failed");
      end
      $finish;
   end

endmodule
